@@ src/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared payload types, operation and status codes, word limits and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

  // Signed word size that results must fit in.
  localparam int unsigned WORD_BITS = 32;
  // Width of the serial divider operands.
  localparam int unsigned DIV_W     = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  localparam logic signed [63:0] WORD_MAX64 = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] WORD_MIN64 = -WORD_MAX64 - 64'sd1;
  localparam logic [DIV_W-1:0]   MAG_POS_MAX = DIV_W'(WORD_MAX64);
  localparam logic [DIV_W-1:0]   MAG_NEG_MAX = DIV_W'(WORD_MAX64) + DIV_W'(1);

  // Operation codes.
  localparam logic [2:0] KIND_ADD   = 3'd0;
  localparam logic [2:0] KIND_SUB   = 3'd1;
  localparam logic [2:0] KIND_MUL   = 3'd2;
  localparam logic [2:0] KIND_DIV   = 3'd3;
  localparam logic [2:0] KIND_NEG   = 3'd4;
  localparam logic [2:0] KIND_RECIP = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  // Multiplier step selects.
  localparam logic [1:0] MSTEP_FIRST  = 2'd0;
  localparam logic [1:0] MSTEP_SECOND = 2'd1;
  localparam logic [1:0] MSTEP_DEN    = 2'd2;

  // Divider operand selects.
  localparam logic [1:0] DSEL_GCD = 2'd0;
  localparam logic [1:0] DSEL_NUM = 2'd1;
  localparam logic [1:0] DSEL_DEN = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] a_num;
    logic [30:0]        a_den;
    logic signed [31:0] b_num;
    logic [30:0]        b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         status;
  } rau_out_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_step;
    logic       check;
    logic       div_start;
    logic [1:0] div_sel;
    logic       gcd_step;
    logic       qn_store;
    logic       qd_store;
    logic       out_load;
  } rau_cmd_t;

  typedef struct packed {
    logic fail;
    logic y_zero;
    logic div_done;
  } rau_stat_t;

endpackage

@@ src/rau_div.sv @@
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [rau_pkg::DIV_W-1:0] dividend_i,
  input  logic [rau_pkg::DIV_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [rau_pkg::DIV_W-1:0] quo_o,
  output logic [rau_pkg::DIV_W-1:0] rem_o
);
  import rau_pkg::*;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_W - 1);

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIV_W-1:0]     dvs_q, dvs_d;
  logic [DIV_W:0]       rem_shift;
  logic [DIV_W:0]       rem_trial;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign rem_shift = {rem_q, quo_q[DIV_W-1]};
  assign rem_trial = rem_shift - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!rem_trial[DIV_W]) begin
        rem_d = rem_trial[DIV_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = rem_shift[DIV_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  // Done is a one-cycle pulse, registered in the cycle after the last step.
  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CNT_LAST);
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  // A new division never starts over one in flight.
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("divider did not go busy");
  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == CNT_LAST) |=> (!busy_q && done_q))
    else $error("divider did not finish after the last step");

endmodule

@@ src/rau_dp.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic datapath
// Operand registers, shared multiplier, range check, Euclid registers,
// serial divider and the result register.
// ----------------------------------------------------------------------------
module rau_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rau_pkg::rau_in_t   in_data_i,
  input  rau_pkg::rau_cmd_t  cmd_i,
  output rau_pkg::rau_stat_t stat_o,
  output rau_pkg::rau_out_t  out_data_o
);
  import rau_pkg::*;

  rau_in_t            op_q;
  logic signed [63:0] p1_q, p2_q, p3_q;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [31:0] ad_s, bd_s;
  logic signed [63:0] an_x, ad_x;
  logic signed [63:0] n64, d64;
  logic [63:0]        n_mag, d_mag;
  logic [1:0]         st_chk;
  logic [1:0]         st_q;
  logic               sign_q;
  logic [DIV_W-1:0]   x_q, y_q, mn_q, md_q, qn_q, qd_q;
  logic [DIV_W-1:0]   dvd, dvs, quo, rem;
  logic               div_done;
  rau_out_t           res_d, res_q;
  logic               ovf;

  // Operand capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= in_data_i;
    end
  end

  assign ad_s = {1'b0, op_q.a_den};
  assign bd_s = {1'b0, op_q.b_den};

  // Shared multiplier operand selection, one product per step.
  always_comb begin
    mul_a = op_q.a_num;
    mul_b = bd_s;
    unique case (cmd_i.mul_step)
      MSTEP_FIRST: begin
        mul_a = op_q.a_num;
        mul_b = (op_q.kind == KIND_MUL) ? op_q.b_num : bd_s;
      end
      MSTEP_SECOND: begin
        mul_a = op_q.b_num;
        mul_b = ad_s;
      end
      MSTEP_DEN: begin
        mul_a = ad_s;
        mul_b = (op_q.kind == KIND_DIV) ? op_q.b_num : bd_s;
      end
      default: begin
        mul_a = op_q.a_num;
        mul_b = bd_s;
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_step)
        MSTEP_FIRST:  p1_q <= prod;
        MSTEP_SECOND: p2_q <= prod;
        default:      p3_q <= prod;
      endcase
    end
  end

  // Raw numerator and denominator.
  assign an_x = 64'(op_q.a_num);
  assign ad_x = {33'b0, op_q.a_den};

  always_comb begin
    n64 = p1_q;
    d64 = p3_q;
    case (op_q.kind)
      KIND_ADD: n64 = p1_q + p2_q;
      KIND_SUB: n64 = p1_q - p2_q;
      KIND_NEG: begin
        n64 = -an_x;
        d64 = ad_x;
      end
      KIND_RECIP: begin
        if (op_q.a_num < 0) begin
          n64 = -ad_x;
          d64 = -an_x;
        end else begin
          n64 = ad_x;
          d64 = an_x;
        end
      end
      default: n64 = p1_q;
    endcase
  end

  // Status before reduction; the invalid operation check comes first, then zero denominators.
  always_comb begin
    st_chk = ST_OK;
    if (op_q.kind > KIND_RECIP) begin
      st_chk = ST_OVF;
    end else if (op_q.a_den == '0 || (op_q.kind < KIND_NEG && op_q.b_den == '0)) begin
      st_chk = ST_DIVZ;
    end else if (op_q.kind == KIND_DIV && op_q.b_num == '0) begin
      st_chk = ST_DIVZ;
    end else if (op_q.kind == KIND_RECIP && op_q.a_num == '0) begin
      st_chk = ST_DIVZ;
    end else if (n64 < WORD_MIN64 || n64 > WORD_MAX64 ||
                 d64 < WORD_MIN64 || d64 > WORD_MAX64) begin
      st_chk = ST_OVF;
    end
  end

  assign n_mag = n64[63] ? -n64 : n64;
  assign d_mag = d64[63] ? -d64 : d64;

  // Divider operand selection.
  always_comb begin
    dvd = x_q;
    dvs = y_q;
    case (cmd_i.div_sel)
      DSEL_NUM: begin
        dvd = mn_q;
        dvs = x_q;
      end
      DSEL_DEN: begin
        dvd = md_q;
        dvs = x_q;
      end
      default: begin
        dvd = x_q;
        dvs = y_q;
      end
    endcase
  end

  rau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  // Range check results and Euclid registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      st_q   <= st_chk;
      sign_q <= n64[63] ^ d64[63];
      x_q    <= n_mag[DIV_W-1:0];
      y_q    <= d_mag[DIV_W-1:0];
      mn_q   <= n_mag[DIV_W-1:0];
      md_q   <= d_mag[DIV_W-1:0];
    end else if (cmd_i.gcd_step) begin
      x_q <= y_q;
      y_q <= rem;
    end
    if (cmd_i.qn_store) begin
      qn_q <= quo;
    end
    if (cmd_i.qd_store) begin
      qd_q <= quo;
    end
  end

  // Final sign placement and range check of the reduced values.
  assign ovf = (qd_q > MAG_POS_MAX) || (sign_q ? (qn_q > MAG_NEG_MAX) : (qn_q > MAG_POS_MAX));

  always_comb begin
    res_d = '0;
    if (st_q != ST_OK) begin
      res_d.status = st_q;
    end else if (ovf) begin
      res_d.status = ST_OVF;
    end else begin
      res_d.res_num = sign_q ? -$signed(qn_q) : $signed(qn_q);
      res_d.res_den = qd_q[30:0];
      res_d.status  = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_q <= res_d;
    end
  end

  assign stat_o.fail     = (st_chk != ST_OK);
  assign stat_o.y_zero   = (y_q == '0);
  assign stat_o.div_done = div_done;
  assign out_data_o      = res_q;

endmodule

@@ src/rau_ctrl.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic controller
// Sequences the multiplier steps, range check, Euclid loop, the two final
// divisions and the output handshake.
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  rau_pkg::rau_stat_t stat_i,
  output rau_pkg::rau_cmd_t  cmd_o
);
  import rau_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL0  = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_MUL2  = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_GCD   = 4'd5;
  localparam logic [3:0] S_GCDW  = 4'd6;
  localparam logic [3:0] S_DIVN  = 4'd7;
  localparam logic [3:0] S_DIVNW = 4'd8;
  localparam logic [3:0] S_DIVD  = 4'd9;
  localparam logic [3:0] S_DIVDW = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc;
  logic       out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = MSTEP_FIRST;
        state_d        = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = MSTEP_SECOND;
        state_d        = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = MSTEP_DEN;
        state_d        = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = stat_i.fail ? S_DONE : S_GCD;
      end
      S_GCD: begin
        if (stat_i.y_zero) begin
          state_d = S_DIVN;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DSEL_GCD;
          state_d         = S_GCDW;
        end
      end
      S_GCDW: begin
        cmd_o.div_sel = DSEL_GCD;
        if (stat_i.div_done) begin
          cmd_o.gcd_step = 1'b1;
          state_d        = S_GCD;
        end
      end
      S_DIVN: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DSEL_NUM;
        state_d         = S_DIVNW;
      end
      S_DIVNW: begin
        cmd_o.div_sel = DSEL_NUM;
        if (stat_i.div_done) begin
          cmd_o.qn_store = 1'b1;
          state_d        = S_DIVD;
        end
      end
      S_DIVD: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DSEL_DEN;
        state_d         = S_DIVDW;
      end
      S_DIVDW: begin
        cmd_o.div_sel = DSEL_DEN;
        if (stat_i.div_done) begin
          cmd_o.qd_store = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid: set on a load, cleared when the beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_MUL0)) else $error("accepted beat did not start");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while stalled");
  a_gcd_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GCDW && stat_i.div_done) |=> (state_q == S_GCD))
    else $error("Euclid loop did not return");

endmodule

@@ src/rational_arithmetic_unit_core.sv @@
// Sequence: an item holds the unit for the multiplier steps and range check,
// then one serial division per Euclid remainder step (at least one), then the
// two final divisions; overflow and division by zero cases go from the range
// check straight to the result. The result beat is then registered for output.
// One beat at a time; all divisions use the shared 32-step serial divider.
// Reset: asynchronous, active low; clears the controller and divider control.
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies, divides, negates or inverts fractions and
// reduces the result by the Euclidean GCD.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rau_pkg::rau_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rau_pkg::rau_out_t out_data_o
);
  import rau_pkg::*;

  rau_cmd_t  cmd;
  rau_stat_t stat;

  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rau_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

@@ verif/rational_arithmetic_unit_core_tb.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives fraction operations through the valid/stall input channel, predicts
// each reduced result in a scoreboard and compares every output beat field by
// field. Sender gaps, receiver stalls and one long receiver hold-off are mixed
// in so that the unit fills up and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import rau_pkg::*;

class fraction_scoreboard;
  rau_out_t pending_q[$];
  int       mismatches;

  function new();
    mismatches = 0;
  endfunction

  // True when v fits the signed word.
  function bit fits_word(longint v);
    return v >= WORD_MIN64 && v <= WORD_MAX64;
  endfunction

  function longint unsigned abs_val(longint v);
    return v < 0 ? 64'd0 - longint'(v) : longint'(v);
  endfunction

  function longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Computes the reduced fraction for one input beat.
  function rau_out_t reduce_fraction(rau_in_t op);
    rau_out_t r;
    longint an, ad, bn, bd, n, d;
    longint unsigned g;
    logic [1:0] st;
    an = op.a_num;
    ad = longint'(op.a_den);
    bn = op.b_num;
    bd = longint'(op.b_den);
    n = 0;
    d = 1;
    st = ST_OK;
    if (op.kind > KIND_RECIP) begin
      st = ST_OVF;
    end else if (ad == 0 || (op.kind < KIND_NEG && bd == 0)) begin
      st = ST_DIVZ;
    end else begin
      case (op.kind)
        KIND_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
        KIND_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
        KIND_MUL: begin n = an * bn; d = ad * bd; end
        KIND_DIV: begin
          if (bn == 0) st = ST_DIVZ;
          else begin n = an * bd; d = ad * bn; end
        end
        KIND_NEG: begin n = -an; d = ad; end
        default: begin
          if (an == 0) st = ST_DIVZ;
          else if (an < 0) begin n = -ad; d = -an; end
          else begin n = ad; d = an; end
        end
      endcase
      if (st == ST_OK && (!fits_word(n) || !fits_word(d))) st = ST_OVF;
      if (st == ST_OK) begin
        g = gcd_of(abs_val(n), abs_val(d));
        n = n / longint'(g);
        d = d / longint'(g);
        if (d < 0) begin n = -n; d = -d; end
        if (!fits_word(n) || !fits_word(d) || d < 1) st = ST_OVF;
      end
    end
    if (st != ST_OK) begin n = 0; d = 0; end
    r.res_num = n[31:0];
    r.res_den = d[30:0];
    r.status  = st;
    return r;
  endfunction

  // Records the expected result of an accepted input beat.
  function void note_input(rau_in_t op);
    pending_q = {pending_q, reduce_fraction(op)};
  endfunction

  // Compares an output beat with the oldest expected result.
  function void check_result(rau_out_t got);
    rau_out_t exp_r;
    if (pending_q.size() == 0) begin
      $error("unexpected output beat num=%0d den=%0d status=%0d",
             got.res_num, got.res_den, got.status);
      mismatches++;
      return;
    end
    exp_r = pending_q.pop_front();
    if (got.res_num !== exp_r.res_num) begin
      $error("res_num expected %0d actual %0d", exp_r.res_num, got.res_num);
      mismatches++;
    end
    if (got.res_den !== exp_r.res_den) begin
      $error("res_den expected %0d actual %0d", exp_r.res_den, got.res_den);
      mismatches++;
    end
    if (got.status !== exp_r.status) begin
      $error("status expected %0d actual %0d", exp_r.status, got.status);
      mismatches++;
    end
  endfunction
endclass

module rational_arithmetic_unit_core_tb;
  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  rau_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  rau_out_t out_data_o;

  fraction_scoreboard sb = new();
  bit stim_done = 1'b0;
  bit hold_request = 1'b0;
  int burst_left = 0;

  rational_arithmetic_unit_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Sends one beat and waits until it is accepted; gaps fall between bursts.
  task automatic send_beat(rau_in_t op);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= op;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(op);
    burst_left--;
  endtask

  task automatic send_op(logic [2:0] k, logic [31:0] an, logic [30:0] ad,
                         logic [31:0] bn, logic [30:0] bd);
    rau_in_t op;
    op.kind = k;
    op.a_num = an;
    op.a_den = ad;
    op.b_num = bn;
    op.b_den = bd;
    send_beat(op);
  endtask

  // Random numerator: mostly small, some mid-size, some full range.
  function automatic logic [31:0] rand_num();
    int c;
    c = $urandom_range(0, 9);
    if (c < 6) return 32'($signed($urandom_range(0, 400)) - 200);
    if (c < 8) return 32'($signed($urandom_range(0, 131070)) - 65535);
    return $urandom();
  endfunction

  function automatic logic [30:0] rand_den();
    int c;
    c = $urandom_range(0, 49);
    if (c == 0) return 31'd0;
    if (c < 30) return 31'($urandom_range(1, 200));
    if (c < 42) return 31'($urandom_range(1, 65535));
    return 31'($urandom_range(1, 32'h7fff_ffff));
  endfunction

  // Stimulus: directed corner cases, then random operations.
  initial begin
    logic [2:0] k;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    send_op(KIND_ADD, 32'd1, 31'd2, 32'd1, 31'd3);
    send_op(KIND_SUB, 32'd1, 31'd2, 32'd1, 31'd2);
    send_op(KIND_MUL, -32'd3, 31'd4, 32'd8, 31'd9);
    send_op(KIND_DIV, 32'd5, 31'd7, -32'd10, 31'd21);
    send_op(KIND_DIV, 32'd5, 31'd7, 32'd0, 31'd3);
    send_op(KIND_NEG, 32'h8000_0000, 31'd1, 32'd0, 31'd0);
    send_op(KIND_NEG, 32'h7fff_ffff, 31'h7fff_ffff, 32'd0, 31'd0);
    send_op(KIND_RECIP, 32'd0, 31'd5, 32'd1, 31'd1);
    send_op(KIND_RECIP, -32'd6, 31'd4, 32'd1, 31'd1);
    send_op(KIND_RECIP, 32'h8000_0000, 31'd1, 32'd1, 31'd1);
    send_op(KIND_RECIP, 32'h7fff_ffff, 31'h7fff_ffff, 32'd1, 31'd1);
    send_op(KIND_ADD, 32'd1, 31'd0, 32'd1, 31'd1);
    send_op(KIND_ADD, 32'd1, 31'd1, 32'd1, 31'd0);
    send_op(KIND_NEG, 32'd3, 31'd0, 32'd1, 31'd1);
    send_op(3'd6, 32'd1, 31'd1, 32'd1, 31'd1);
    send_op(3'd7, 32'hffff_ffff, 31'h7fff_ffff, 32'hffff_ffff, 31'h7fff_ffff);
    send_op(KIND_ADD, 32'h7fff_ffff, 31'd1, 32'h7fff_ffff, 31'd1);
    send_op(KIND_MUL, 32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    send_op(KIND_MUL, 32'h8000_0000, 31'd1, 32'hffff_ffff, 31'd1);
    send_op(KIND_ADD, 32'd0, 31'd7, 32'd0, 31'd9);
    send_op(KIND_DIV, 32'd1, 31'd1, 32'h8000_0000, 31'd1);
    send_op(KIND_SUB, 32'd6, 31'd4, -32'd9, 31'd6);
    hold_request = 1'b1;
    for (int i = 0; i < 1700; i++) begin
      k = $urandom_range(0, 99) < 3 ? 3'($urandom_range(6, 7))
                                      : 3'($urandom_range(0, 5));
      send_op(k, rand_num(), rand_den(), rand_num(), rand_den());
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver stalls: random pattern, quiet stretches, and one long hold-off.
  initial begin
    int mode_len;
    int mode;
    bit held;
    forever begin
      @(negedge clk_i);
      if (hold_request && !held) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (3000) @(negedge clk_i);
        out_stall_i <= 1'b0;
        mode_len = 0;
      end else if (mode_len == 0) begin
        mode = $urandom_range(0, 2);
        mode_len = $urandom_range(20, 400);
      end else begin
        mode_len--;
        out_stall_i <= (mode == 0) ? 1'b0 :
                       (mode == 1) ? ($urandom_range(0, 3) == 0)
                                   : ($urandom_range(0, 1) == 0);
      end
    end
  end

  // Output monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // End of run.
  initial begin
    wait (stim_done);
    wait (sb.pending_q.size() == 0);
    repeat (2000) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #40000000;
    $display("simulation failed");
    $finish;
  end
endmodule
